// ----- src/iadc_pkg.sv -----
// ----------------------------------------------------------------------------
// iadc_pkg
// Shared widths, constants and types of the interleaved ADC channel averager.
// ----------------------------------------------------------------------------
package iadc_pkg;

    localparam int SMP_W      = 16;
    localparam int SUM_W      = 24;
    localparam int FS_W       = 16;
    localparam int CFG_CH_W   = 5;
    localparam int SPC_W      = 8;
    localparam int CHAN_W     = 4;
    localparam int AVG_W      = 16;
    localparam int PCT_W      = 14;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int PCT_UNIT = 100;
    localparam int PCT_FULL = PCT_UNIT * PCT_UNIT;

    // divider sized for avg * 10000 < 2**30 and a 16-bit full-scale divisor
    localparam int DIV_NUM_W = 30;
    localparam int DIV_DEN_W = 16;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

    localparam logic [FS_W-1:0]     FS_RST  = 16'd4095;
    localparam logic [CFG_CH_W-1:0] NCH_RST = 5'd1;
    localparam logic [SPC_W-1:0]    SPC_RST = 8'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FULL_SCALE    = 2'd0,
        CFG_CHANNEL_COUNT = 2'd1,
        CFG_SAMPLES_PER_CH = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [DIV_NUM_W-1:0] quo;
    } t_div_rsp;

endpackage

// ----- src/iadc_if.sv -----
// ----------------------------------------------------------------------------
// iadc channel interfaces
// Sample input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface iadc_smp_if;
    import iadc_pkg::*;

    logic             valid;
    logic             ready;
    logic [SMP_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface iadc_res_if;
    import iadc_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] chan;
    logic [AVG_W-1:0]  average;
    logic [PCT_W-1:0]  percent_hundredths;
    logic              last;

    modport source (output valid, output chan, output average,
                    output percent_hundredths, output last, input ready);
    modport sink   (input valid, input chan, input average,
                    input percent_hundredths, input last, output ready);
endinterface

interface iadc_cfg_if;
    import iadc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- src/iadc_div.sv -----
// ----------------------------------------------------------------------------
// iadc_div
// Restoring divider, one quotient bit per cycle, shared by the average and
// the percentage computation.
// ----------------------------------------------------------------------------
module iadc_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  iadc_pkg::t_div_req i_req,
    output iadc_pkg::t_div_rsp o_rsp
);
    import iadc_pkg::*;

    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_done;
    logic [DIV_NUM_W-1:0] r_quo;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_den;

    logic [DIV_DEN_W:0]   trial;
    logic                 ge;
    logic [DIV_DEN_W-1:0] n_rem;

    always_comb begin
        trial = {r_rem, r_quo[DIV_NUM_W-1]};
        ge    = trial >= {1'b0, r_den};
        n_rem = ge ? DIV_DEN_W'(trial - {1'b0, r_den}) : trial[DIV_DEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_cnt <= DIV_CNT_W'(DIV_NUM_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.num;
            r_rem <= '0;
            r_den <= i_req.den;
        end else if (r_cnt != '0) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[DIV_NUM_W-2:0], ge};
        end
    end

    assign o_rsp.busy = (r_cnt != '0);
    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

// ----- src/interleaved_adc_channel_averager.sv -----
// ----------------------------------------------------------------------------
// interleaved_adc_channel_averager
// Per-channel accumulation of interleaved ADC samples with a frame-end
// average and percent-of-full-scale result for every channel.
// ----------------------------------------------------------------------------
// Sample: accept, accumulator read, write back (S_IDLE, S_ARD, S_AWR); ready again after.
// Frame end: per channel the 30-step shared divider runs twice (sum / samples,
// then avg * 10000 / full_scale, skipped with zero full scale) plus a multiply.
// First result follows the frame's final sample through S_RRD, S_D1, S_D1W,
// S_MUL, S_D2, S_D2W (not with zero full scale) and S_EMIT.
// Reset: registers to defaults, accumulators marked empty by per-channel
// valid bits at once; no clearing pass.
// ----------------------------------------------------------------------------
module interleaved_adc_channel_averager #(
    parameter int MAX_CHANNELS = 16,
    parameter int SAMPLE_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    iadc_cfg_if.sink    i_cfg,
    iadc_smp_if.sink    i_smp,
    iadc_res_if.source  o_res
);
    import iadc_pkg::*;

    localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CMP_W = (CH_W + 1 > CFG_CH_W) ? CH_W + 1 : CFG_CH_W;

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_ARD  = 10'b0000000010,
        S_AWR  = 10'b0000000100,
        S_RRD  = 10'b0000001000,
        S_D1   = 10'b0000010000,
        S_D1W  = 10'b0000100000,
        S_MUL  = 10'b0001000000,
        S_D2   = 10'b0010000000,
        S_D2W  = 10'b0100000000,
        S_EMIT = 10'b1000000000
    } t_state;

    t_state                 r_state;
    logic [FS_W-1:0]        r_fs;
    logic [CFG_CH_W-1:0]    r_nch;
    logic [SPC_W-1:0]       r_spc;
    logic [MAX_CHANNELS-1:0] r_vld;
    logic [CH_W-1:0]        r_next_ch;
    logic [SPC_W-1:0]       r_round;
    logic [CH_W-1:0]        r_ch;
    logic [SAMPLE_BITS-1:0] r_smp;
    logic [AVG_W-1:0]       r_avg;
    logic [DIV_NUM_W-1:0]   r_prod;
    logic [PCT_W-1:0]       r_pct;

    logic [SUM_W-1:0]       r_mem [MAX_CHANNELS];
    logic [SUM_W-1:0]       r_mem_q;

    logic                   r_out_valid;
    logic [CHAN_W-1:0]      r_out_chan;
    logic [AVG_W-1:0]       r_out_avg;
    logic [PCT_W-1:0]       r_out_pct;
    logic                   r_out_last;

    logic [CMP_W-1:0]       nch_cfg;
    logic [CMP_W-1:0]       nch_eff;
    logic [SPC_W-1:0]       spc_eff;
    logic [CH_W-1:0]        rd_addr;
    logic [SUM_W-1:0]       stored_sum;
    logic [SUM_W-1:0]       new_sum;
    logic                   row_done;
    logic                   frame_done;
    logic                   ch_last;
    logic                   smp_fire;
    logic                   cfg_fire;
    logic                   emit_fire;
    logic [PCT_W-1:0]       pct_sat;
    logic                   mem_we;

    t_div_req               div_req;
    t_div_rsp               div_rsp;

    iadc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        nch_cfg = CMP_W'(r_nch);
        priority if (nch_cfg == '0) begin
            nch_eff = CMP_W'(1);
        end else if (nch_cfg > CMP_W'(MAX_CHANNELS)) begin
            nch_eff = CMP_W'(MAX_CHANNELS);
        end else begin
            nch_eff = nch_cfg;
        end
        spc_eff    = (r_spc == '0) ? SPC_W'(1) : r_spc;
        rd_addr    = (r_state == S_ARD) ? r_next_ch : r_ch;
        stored_sum = r_vld[rd_addr] ? r_mem_q : '0;
        new_sum    = (r_vld[r_next_ch] ? r_mem_q : '0) + SUM_W'(r_smp);
        row_done   = (CMP_W'(r_next_ch) + CMP_W'(1)) == nch_eff;
        frame_done = ({1'b0, r_round} + 9'd1) >= {1'b0, spc_eff};
        ch_last    = (CMP_W'(r_ch) + CMP_W'(1)) == nch_eff;
        pct_sat    = (div_rsp.quo > DIV_NUM_W'(PCT_FULL)) ? PCT_W'(PCT_FULL)
                                                          : div_rsp.quo[PCT_W-1:0];
        smp_fire   = i_smp.valid && (r_state == S_IDLE);
        cfg_fire   = i_cfg.valid;
        emit_fire  = (r_state == S_EMIT) && (!r_out_valid || o_res.ready);
        mem_we     = (r_state == S_AWR);

        div_req.start = 1'b0;
        div_req.num   = DIV_NUM_W'(stored_sum);
        div_req.den   = DIV_DEN_W'(spc_eff);
        if (r_state == S_D1) begin
            div_req.start = 1'b1;
        end else if (r_state == S_D2) begin
            div_req.start = (r_fs != '0);
            div_req.num   = r_prod;
            div_req.den   = r_fs;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mem_q <= r_mem[rd_addr];
        if (mem_we) begin
            r_mem[r_next_ch] <= new_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (smp_fire) begin
            r_smp <= i_smp.sample[SAMPLE_BITS-1:0];
        end
        if (r_state == S_D1W && div_rsp.done) begin
            r_avg <= div_rsp.quo[AVG_W-1:0];
        end
        if (r_state == S_MUL) begin
            r_prod <= DIV_NUM_W'(r_avg) * DIV_NUM_W'(PCT_FULL);
        end
        if (r_state == S_D2 && r_fs == '0) begin
            r_pct <= PCT_W'(PCT_FULL);
        end else if (r_state == S_D2W && div_rsp.done) begin
            r_pct <= pct_sat;
        end
        if (emit_fire) begin
            r_out_chan <= CHAN_W'(r_ch);
            r_out_avg  <= r_avg;
            r_out_pct  <= r_pct;
            r_out_last <= ch_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fs        <= FS_RST;
            r_nch       <= NCH_RST;
            r_spc       <= SPC_RST;
            r_vld       <= '0;
            r_next_ch   <= '0;
            r_round     <= '0;
            r_ch        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (smp_fire) begin
                        r_state <= S_ARD;
                    end
                end
                S_ARD: begin
                    r_state <= S_AWR;
                end
                S_AWR: begin
                    r_vld[r_next_ch] <= 1'b1;
                    r_state          <= S_IDLE;
                    if (row_done) begin
                        r_next_ch <= '0;
                        if (frame_done) begin
                            r_round <= '0;
                            r_ch    <= '0;
                            r_state <= S_RRD;
                        end else begin
                            r_round <= r_round + 1'b1;
                        end
                    end else begin
                        r_next_ch <= r_next_ch + 1'b1;
                    end
                end
                S_RRD: begin
                    r_state <= S_D1;
                end
                S_D1: begin
                    r_state <= S_D1W;
                end
                S_D1W: begin
                    if (div_rsp.done) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_D2;
                end
                S_D2: begin
                    r_state <= (r_fs == '0) ? S_EMIT : S_D2W;
                end
                S_D2W: begin
                    if (div_rsp.done) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (emit_fire) begin
                        r_out_valid <= 1'b1;
                        if (ch_last) begin
                            r_vld   <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_ch    <= r_ch + 1'b1;
                            r_state <= S_RRD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (cfg_fire) begin
                unique case (t_cfg_idx'(i_cfg.index))
                    CFG_FULL_SCALE: begin
                        r_fs <= i_cfg.data[FS_W-1:0];
                    end
                    CFG_CHANNEL_COUNT: begin
                        r_nch     <= i_cfg.data[CFG_CH_W-1:0];
                        r_vld     <= '0;
                        r_next_ch <= '0;
                        r_round   <= '0;
                    end
                    CFG_SAMPLES_PER_CH: begin
                        r_spc     <= i_cfg.data[SPC_W-1:0];
                        r_vld     <= '0;
                        r_next_ch <= '0;
                        r_round   <= '0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign i_cfg.ready = 1'b1;
    assign i_smp.ready = (r_state == S_IDLE);

    assign o_res.valid              = r_out_valid;
    assign o_res.chan               = r_out_chan;
    assign o_res.average            = r_out_avg;
    assign o_res.percent_hundredths = r_out_pct;
    assign o_res.last               = r_out_last;

    // the divider only runs while the sample port is closed
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !div_rsp.busy)
        else $error("divider busy while accepting samples");

    // frame end leaves all accumulators empty
    a_frame_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit_fire && ch_last) |=> (r_vld == '0))
        else $error("accumulators not cleared after frame");

    // a result held back by the sink is never overwritten
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_res.ready) |=> (r_out_valid && $stable(r_out_chan)))
        else $error("pending result overwritten");

endmodule
